// ----- rtl/fdc_pkg.sv -----
// ============================================================================
// fdc_pkg
// Shared types and constants of the frame deframer with checksum check.
// ============================================================================
package fdc_pkg;

  // Frame geometry.
  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX        = 10'd1023;
  localparam logic [POS_W-1:0] POS_DELIMITER  = 10'd0;
  localparam logic [POS_W-1:0] POS_LEN_HIGH   = 10'd1;
  localparam logic [POS_W-1:0] POS_LEN_LOW    = 10'd2;
  localparam logic [POS_W-1:0] SUM_START      = 10'd3;
  localparam logic [POS_W-1:0] HOST_POS       = 10'd4;
  localparam logic [POS_W-1:0] PAYLOAD_OFFSET = 10'd19;
  localparam logic [15:0]      HEADER_BYTES   = 16'd16;
  localparam logic [15:0]      MAX_FRAME_LEN  = 16'd511;
  localparam logic [15:0]      COUNT_MAX      = 16'd511;
  localparam logic [7:0]       CSUM_GOOD      = 8'hFF;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_DELIMITER  = 2'd0;
  localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;
  localparam logic [7:0] DELIMITER_RST  = 8'h7E;
  localparam logic [8:0] MIN_LENGTH_RST = 9'd5;
  localparam logic [8:0] MAX_LENGTH_RST = 9'd511;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // End-of-frame status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DELIM = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_CSUM  = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [8:0] min_length;
    logic [8:0] max_length;
  } fdc_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [15:0]      frame_len;
    logic [7:0]       sum;
    logic             delim_ok;
    logic             host_req;
    logic             csum_seen;
  } fdc_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_e    status;
    logic       host_request;
    logic [8:0] payload_count;
  } fdc_result_t;

endpackage

// ----- rtl/fdc_in_if.sv -----
// ============================================================================
// fdc_in_if
// Byte stream channel into the deframer: one received byte per transfer.
// ============================================================================
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// ----- rtl/fdc_out_if.sv -----
// ============================================================================
// fdc_out_if
// Result channel of the deframer: payload bytes and end-of-frame status.
// ============================================================================
interface fdc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic       host_request;
  logic [8:0] payload_count;

  modport source (output valid, output kind, output payload_byte, output status,
                  output host_request, output payload_count, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input host_request, input payload_count, output ready);
endinterface

// ----- rtl/frame_deframer_checksum_top.sv -----
// ============================================================================
// frame_deframer_checksum_top
// Byte-wide frame deframer: checks delimiter, length range and checksum,
// passes payload bytes out and ends each buffer with a status result.
// ============================================================================
//
//  Channel   Dir  Handshake        Contents
//  rx_i      in   valid/ready      rx_byte, end_of_buffer
//  res_o     out  valid/ready      kind, payload_byte, status, host_request,
//                                  payload_count
//  cfg_*_i   in   write enable     index 0 delimiter, 1 min_length, 2 max_length
//
//  One byte is taken every cycle unless the result stalls; each byte is held
//  in the input register and its result, if any, is registered in the result
//  register. Checksum add and length compares form the single stage between.
//  Reset clears frame state and both valid flags; config takes reset values.
//  A stalled result stops the input register; bytes keep flowing as long as
//  the result register is empty or being taken.
//
module frame_deframer_checksum_top
  import fdc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [8:0]    cfg_data_i,
  fdc_in_if.sink        rx_i,
  fdc_out_if.source     res_o
);

  fdc_cfg_t    cfg_q;
  fdc_state_t  state_q;
  fdc_state_t  state_d;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eob_q;
  logic        out_valid_q;
  fdc_result_t out_q;
  fdc_result_t step_result;
  logic        step_has_result;
  logic        advance;
  logic        rx_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter  <= DELIMITER_RST;
      cfg_q.min_length <= MIN_LENGTH_RST;
      cfg_q.max_length <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELIMITER:  cfg_q.delimiter  <= cfg_data_i[7:0];
        CFG_MIN_LENGTH: cfg_q.min_length <= cfg_data_i;
        CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The input register moves on when the result register can take its result.
  assign advance  = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_ready = !in_valid_q || advance;
  assign rx_i.ready = rx_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
      in_eob_q  <= rx_i.end_of_buffer;
    end
  end

  fdc_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .rx_byte_i    (in_byte_q),
    .eob_i        (in_eob_q),
    .state_o      (state_d),
    .has_result_o (step_has_result),
    .result_o     (step_result)
  );

  // Frame state advances once per byte leaving the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_has_result;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_has_result) begin
      out_q <= step_result;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_q.kind;
  assign res_o.payload_byte  = out_q.payload_byte;
  assign res_o.status        = out_q.status;
  assign res_o.host_request  = out_q.host_request;
  assign res_o.payload_count = out_q.payload_count;

  // An end-of-buffer byte restarts the frame.
  a_eob_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_eob_q |=> state_q.pos == '0)
    else $error("frame state not cleared after end of buffer");

  // Payload only flows for frames longer than the header.
  a_payload_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == KIND_PAYLOAD) |-> out_q.payload_count != '0)
    else $error("payload result with zero payload count");

  // The checksum byte cannot come before the sum start.
  a_csum_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.csum_seen |-> state_q.pos > SUM_START)
    else $error("checksum seen before its earliest position");

  // An empty result register never blocks the input.
  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> rx_ready)
    else $error("input stalled with empty result register");

endmodule

// ----- rtl/fdc_step.sv -----
// ============================================================================
// fdc_step
// Per-byte frame logic: next frame state and the result caused by one byte.
// ============================================================================
module fdc_step
  import fdc_pkg::*;
(
  input  fdc_cfg_t    cfg_i,
  input  fdc_state_t  state_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        eob_i,
  output fdc_state_t  state_o,
  output logic        has_result_o,
  output fdc_result_t result_o
);

  fdc_state_t  upd;
  logic [15:0] len_next;
  logic [16:0] cs_pos;
  logic [16:0] pos_ext;
  logic        len_good;
  logic [15:0] count_raw;
  logic [8:0]  count;
  logic        payload_hit;

  assign pos_ext = {7'b0, state_i.pos};

  // Length field as it stands once this byte is taken.
  always_comb begin
    len_next = state_i.frame_len;
    if (state_i.pos == POS_LEN_HIGH) begin
      len_next = {rx_byte_i, 8'h00};
    end else if (state_i.pos == POS_LEN_LOW) begin
      len_next = {state_i.frame_len[15:8], rx_byte_i};
    end
  end

  // The checksum byte sits right after the length field's span.
  assign cs_pos = {1'b0, len_next} + {7'b0, SUM_START};

  // Header fields, position counter and running checksum.
  always_comb begin
    upd           = state_i;
    upd.frame_len = len_next;
    if (state_i.pos == POS_DELIMITER) begin
      upd.delim_ok = (rx_byte_i == cfg_i.delimiter);
    end
    if (state_i.pos == HOST_POS) begin
      upd.host_req = rx_byte_i[0];
    end
    if ((state_i.pos >= SUM_START) && (pos_ext <= cs_pos) && !state_i.csum_seen) begin
      upd.sum = state_i.sum + rx_byte_i;
      if (pos_ext == cs_pos) begin
        upd.csum_seen = 1'b1;
      end
    end
    if (state_i.pos != POS_MAX) begin
      upd.pos = state_i.pos + 10'd1;
    end
  end

  assign len_good = (upd.frame_len >= {7'b0, cfg_i.min_length}) &&
                    (upd.frame_len <= {7'b0, cfg_i.max_length}) &&
                    (upd.frame_len <= MAX_FRAME_LEN);

  // Payload count: length minus header, floored at zero, saturated.
  assign count_raw = upd.frame_len - HEADER_BYTES;
  always_comb begin
    if ((upd.pos < SUM_START) || (upd.frame_len <= HEADER_BYTES)) begin
      count = '0;
    end else if (count_raw > COUNT_MAX) begin
      count = COUNT_MAX[8:0];
    end else begin
      count = count_raw[8:0];
    end
  end

  assign payload_hit = (state_i.pos >= PAYLOAD_OFFSET) && (pos_ext < cs_pos) &&
                       (state_i.pos >= SUM_START) && upd.delim_ok && len_good;

  // Result selection and end-of-buffer restart.
  always_comb begin
    result_o               = '0;
    result_o.host_request  = upd.host_req;
    result_o.payload_count = count;
    result_o.status        = ST_OK;
    has_result_o           = 1'b0;
    state_o                = upd;
    if (eob_i) begin
      has_result_o  = 1'b1;
      result_o.kind = KIND_STATUS;
      priority if (!upd.delim_ok) begin
        result_o.status = ST_BAD_DELIM;
      end else if (state_i.pos < POS_LEN_LOW) begin
        result_o.status = ST_SHORT;
      end else if (!len_good) begin
        result_o.status = ST_BAD_LEN;
      end else if (!upd.csum_seen) begin
        result_o.status = ST_SHORT;
      end else if (upd.sum != CSUM_GOOD) begin
        result_o.status = ST_BAD_CSUM;
      end else begin
        result_o.status = ST_OK;
      end
      state_o = '0;
    end else if (payload_hit) begin
      has_result_o          = 1'b1;
      result_o.kind         = KIND_PAYLOAD;
      result_o.payload_byte = rx_byte_i;
    end
  end

endmodule
